[rtl/rzb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzb_pkg
// Shared widths, depth limits, register indexes and box setup helper.
// ----------------------------------------------------------------------------
package rzb_pkg;

  localparam int COORD_W = 16;  // 12.4 vertex coordinate
  localparam int DEPTH_W = 24;
  localparam int POS_W   = 13;  // whole-pixel scan position, signed
  localparam int DIFF_W  = 17;  // vertex difference
  localparam int CX_W    = 18;  // vertex minus pixel center
  localparam int XP_W    = 38;  // cross product terms, signed
  localparam int SHADE_W = 8;
  localparam int PIX_W   = 11;
  localparam int DIM_W   = 10;
  localparam int CFG_W   = 11;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 24'sh800000;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 24'sh7FFFFF;
  localparam logic signed [XP_W-1:0]    AREA_MIN  = 38'sd256;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_OFFX   = 2'd2,
    CFG_OFFY   = 2'd3
  } cfg_idx_t;

  // truncate toward zero to whole pixels, then offset by one
  function automatic logic signed [POS_W-1:0] box_coord(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] q;
    q = v >>> 4;
    if (v[COORD_W-1] && (v[3:0] != 4'd0)) q = q + 16'sd1;
    return POS_W'(q) + 13'sd1;
  endfunction

endpackage

[rtl/rzb_depth_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzb_depth_mem
// Depth store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rzb_depth_mem #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/rzb_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzb_divider
// Restoring divider, one quotient bit per cycle: quo = floor(num*2^(QUO_W-1)/den)
// for num <= den.
// ----------------------------------------------------------------------------
module rzb_divider #(
  parameter int NUM_W = 38,
  parameter int QUO_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W:0]   rem;
  logic [NUM_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             ge;
  logic [NUM_W:0]   diff;

  assign ge   = rem >= {1'b0, dvs};
  assign diff = ge ? rem - {1'b0, dvs} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= {diff[NUM_W-1:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

[rtl/triangle_zbuffer_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer
// Barycentric triangle scan with depth store; one beat in, one beat out.
// ----------------------------------------------------------------------------
// Load beat: result via S_LD_MUL, S_LD_FIN and S_DONE. Scan beat: past the scan end
// straight to S_DONE; uncovered or off-screen pixel via S_XP_MUL, S_XP_CHK; covered
// one also via S_DIV (serial weight dividers, one bit a cycle), S_ZMUL, S_ZSUM. One
// beat at a time; the next can be taken the cycle after the result beat is issued.
// Reset: after rst a clearing pass over every depth store address fills the
// depth store with the most negative depth; no input beat is taken meanwhile.
module triangle_zbuffer_rasterizer #(
  parameter int MAX_WIDTH        = 512,
  parameter int MAX_HEIGHT       = 512,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v0_x,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v0_y,
  input  logic signed [rzb_pkg::DEPTH_W-1:0]    v0_z,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v1_x,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v1_y,
  input  logic signed [rzb_pkg::DEPTH_W-1:0]    v1_z,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v2_x,
  input  logic signed [rzb_pkg::COORD_W-1:0]    v2_y,
  input  logic signed [rzb_pkg::DEPTH_W-1:0]    v2_z,
  input  logic        [rzb_pkg::SHADE_W-1:0]    flat_shade,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  written,
  output logic signed [rzb_pkg::PIX_W-1:0]      pixel_x,
  output logic signed [rzb_pkg::PIX_W-1:0]      pixel_y,
  output logic signed [rzb_pkg::DEPTH_W-1:0]    depth,
  output logic        [rzb_pkg::SHADE_W-1:0]    shade,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [1:0]                     cfg_index,
  input  logic        [rzb_pkg::CFG_W-1:0]      cfg_data
);

  localparam int F      = WEIGHT_FRAC_BITS;
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SW_W   = ($clog2(MAX_WIDTH + 1) > rzb_pkg::DIM_W) ?
                          $clog2(MAX_WIDTH + 1) : rzb_pkg::DIM_W;
  localparam int SH_W   = ($clog2(MAX_HEIGHT + 1) > rzb_pkg::DIM_W) ?
                          $clog2(MAX_HEIGHT + 1) : rzb_pkg::DIM_W;
  localparam int RP_W   = rzb_pkg::POS_W + SW_W + 1;
  localparam int Q_W    = F + 1;
  localparam int W_W    = F + 2;
  localparam int ACC_W  = W_W + rzb_pkg::DEPTH_W + 2;
  localparam int XP_W   = rzb_pkg::XP_W;
  localparam int POS_W  = rzb_pkg::POS_W;
  localparam logic signed [W_W-1:0] ONE_W = W_W'(1) << F;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LD_MUL = 9'b000000010,
    S_LD_FIN = 9'b000000100,
    S_XP_MUL = 9'b000001000,
    S_XP_CHK = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_ZMUL   = 9'b001000000,
    S_ZSUM   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [rzb_pkg::DIM_W-1:0]     scr_w, scr_h;
  logic signed [rzb_pkg::PIX_W-1:0] off_x, off_y;

  // triangle state
  logic signed [rzb_pkg::COORD_W-1:0] vx [3];
  logic signed [rzb_pkg::COORD_W-1:0] vy [3];
  logic signed [rzb_pkg::DEPTH_W-1:0] vz [3];
  logic [rzb_pkg::SHADE_W-1:0]        shade_h;
  logic signed [POS_W-1:0]            bx0, bx1, by0, by1, sx, sy;
  logic signed [XP_W-1:0]             rz;
  logic                               degen;

  // working registers
  logic signed [XP_W-1:0]  p0, p1, p2, p3;
  logic signed [RP_W-1:0]  row_prod;
  logic [ADDR_W-1:0]       pix_addr;
  logic signed [ACC_W-1:0] m0, m1, m2;
  logic                    do_adv;
  logic                    res_written;
  logic signed [rzb_pkg::PIX_W-1:0]   res_px, res_py;
  logic signed [rzb_pkg::DEPTH_W-1:0] res_depth;
  logic [rzb_pkg::SHADE_W-1:0]        res_shade;

  // clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = clearing || (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= rzb_pkg::DIM_W'(512);
      scr_h <= rzb_pkg::DIM_W'(512);
      off_x <= '0;
      off_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rzb_pkg::cfg_idx_t'(cfg_index))
        rzb_pkg::CFG_WIDTH:  scr_w <= cfg_data[rzb_pkg::DIM_W-1:0];
        rzb_pkg::CFG_HEIGHT: scr_h <= cfg_data[rzb_pkg::DIM_W-1:0];
        rzb_pkg::CFG_OFFX:   off_x <= cfg_data;
        rzb_pkg::CFG_OFFY:   off_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SW_W-1:0] wsat;
  logic [SH_W-1:0] hsat;
  assign wsat = (SW_W'(scr_w) > SW_W'(MAX_WIDTH))  ? SW_W'(MAX_WIDTH)  : SW_W'(scr_w);
  assign hsat = (SH_W'(scr_h) > SH_W'(MAX_HEIGHT)) ? SH_W'(MAX_HEIGHT) : SH_W'(scr_h);

  // load setup
  logic signed [POS_W-1:0] tx0, tx1, tx2, ty0, ty1, ty2;
  logic signed [POS_W-1:0] nbx0, nbx1, nby0, nby1;
  always_comb begin
    tx0 = rzb_pkg::box_coord(v0_x);
    tx1 = rzb_pkg::box_coord(v1_x);
    tx2 = rzb_pkg::box_coord(v2_x);
    ty0 = rzb_pkg::box_coord(v0_y);
    ty1 = rzb_pkg::box_coord(v1_y);
    ty2 = rzb_pkg::box_coord(v2_y);
    nbx0 = (tx0 < tx1) ? tx0 : tx1;
    nbx0 = (nbx0 < tx2) ? nbx0 : tx2;
    nbx1 = (tx0 > tx1) ? tx0 : tx1;
    nbx1 = (nbx1 > tx2) ? nbx1 : tx2;
    nby0 = (ty0 < ty1) ? ty0 : ty1;
    nby0 = (nby0 < ty2) ? nby0 : ty2;
    nby1 = (ty0 > ty1) ? ty0 : ty1;
    nby1 = (nby1 > ty2) ? nby1 : ty2;
  end

  // edge differences
  logic signed [rzb_pkg::DIFF_W-1:0] ax, bx, ay, by;
  logic signed [rzb_pkg::CX_W-1:0]   cx, cy;
  always_comb begin
    ax = rzb_pkg::DIFF_W'(vx[2]) - rzb_pkg::DIFF_W'(vx[0]);
    bx = rzb_pkg::DIFF_W'(vx[1]) - rzb_pkg::DIFF_W'(vx[0]);
    ay = rzb_pkg::DIFF_W'(vy[2]) - rzb_pkg::DIFF_W'(vy[0]);
    by = rzb_pkg::DIFF_W'(vy[1]) - rzb_pkg::DIFF_W'(vy[0]);
    cx = rzb_pkg::CX_W'(vx[0]) - (rzb_pkg::CX_W'(sx) <<< 4);
    cy = rzb_pkg::CX_W'(vy[0]) - (rzb_pkg::CX_W'(sy) <<< 4);
  end

  // coverage test, sign normalized to rz > 0
  logic signed [XP_W-1:0] rx_raw, ry_raw, rxn, ryn, rzn;
  logic signed [XP_W:0]   rsum;
  logic                   covered, in_bounds;
  logic signed [RP_W-1:0] addr_full;
  always_comb begin
    rx_raw = p0 - p1;
    ry_raw = p2 - p3;
    rxn    = rz[XP_W-1] ? -rx_raw : rx_raw;
    ryn    = rz[XP_W-1] ? -ry_raw : ry_raw;
    rzn    = rz[XP_W-1] ? -rz : rz;
    rsum   = (XP_W+1)'(rxn) + (XP_W+1)'(ryn);
    covered = !degen && !rxn[XP_W-1] && !ryn[XP_W-1] && (rsum <= (XP_W+1)'(rzn));
    in_bounds = (sx > 0) && (sy > 0)
             && (RP_W'(sx) < RP_W'(signed'({1'b0, wsat})))
             && (RP_W'(sy) < RP_W'(signed'({1'b0, hsat})));
    addr_full = RP_W'(sx) + row_prod;
  end

  // weights
  logic            div_busy1, div_busy2, div_start;
  logic [Q_W-1:0]  q1, q2;
  assign div_start = (state == S_XP_CHK) && covered && in_bounds;

  rzb_divider #(.NUM_W(XP_W), .QUO_W(Q_W)) u_div_w1 (
    .clk(clk), .rst(rst), .start(div_start), .num(ryn), .den(rzn),
    .busy(div_busy1), .quo(q1)
  );

  rzb_divider #(.NUM_W(XP_W), .QUO_W(Q_W)) u_div_w2 (
    .clk(clk), .rst(rst), .start(div_start), .num(rxn), .den(rzn),
    .busy(div_busy2), .quo(q2)
  );

  logic signed [W_W-1:0] w0, w1, w2;
  always_comb begin
    w1 = signed'({1'b0, q1});
    w2 = signed'({1'b0, q2});
    w0 = ONE_W - w1 - w2;
  end

  // depth interpolation, floor shift and saturation
  logic signed [ACC_W-1:0]           acc, dq;
  logic signed [rzb_pkg::DEPTH_W-1:0] dz;
  always_comb begin
    acc = m0 + m1 + m2;
    dq  = acc >>> F;
    if (dq > ACC_W'(rzb_pkg::DEPTH_MAX))      dz = rzb_pkg::DEPTH_MAX;
    else if (dq < ACC_W'(rzb_pkg::DEPTH_MIN)) dz = rzb_pkg::DEPTH_MIN;
    else                                      dz = rzb_pkg::DEPTH_W'(dq);
  end

  // depth store
  logic                       mem_we, mem_re, pix_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [rzb_pkg::DEPTH_W-1:0] mem_wdata, mem_rdata;
  logic                       depth_pass;

  assign depth_pass = dz > signed'(mem_rdata);
  assign pix_we     = (state == S_ZSUM) && depth_pass;
  assign mem_we     = clearing || pix_we;
  assign mem_waddr  = clearing ? clr_addr : pix_addr;
  assign mem_wdata  = clearing ? rzb_pkg::DEPTH_MIN : dz;
  assign mem_re     = (state == S_XP_CHK);

  rzb_depth_mem #(.ADDR_W(ADDR_W), .DATA_W(rzb_pkg::DEPTH_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(addr_full[ADDR_W-1:0]), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  // scan advance
  logic signed [POS_W-1:0] sx_next, sy_next;
  always_comb begin
    sx_next = sx;
    sy_next = sy;
    if (do_adv) begin
      sx_next = sx + 13'sd1;
      if (sx_next == bx1) begin
        sx_next = bx0;
        sy_next = sy + 13'sd1;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bx0 <= '0; bx1 <= '0; by0 <= '0; by1 <= '0;
      sx  <= '0; sy  <= '0;
      rz  <= '0;
      degen   <= 1'b1;
      shade_h <= '0;
      do_adv  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0; vy[i] <= '0; vz[i] <= '0;
      end
    end else begin
      // S_DONE reloads the output register itself when it is free
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_written <= 1'b0;
            res_px <= '0; res_py <= '0; res_depth <= '0; res_shade <= '0;
            if (!mode) begin
              vx[0] <= v0_x; vy[0] <= v0_y; vz[0] <= v0_z;
              vx[1] <= v1_x; vy[1] <= v1_y; vz[1] <= v1_z;
              vx[2] <= v2_x; vy[2] <= v2_y; vz[2] <= v2_z;
              shade_h <= flat_shade;
              bx0 <= nbx0; bx1 <= nbx1; by0 <= nby0; by1 <= nby1;
              sx  <= nbx0;
              sy  <= (nbx0 == nbx1) ? nby1 : nby0;
              do_adv <= 1'b0;
              state  <= S_LD_MUL;
            end else if (sy == by1) begin
              do_adv <= 1'b0;   // scan finished: stays put
              state  <= S_DONE;
            end else begin
              do_adv <= 1'b1;
              state  <= S_XP_MUL;
            end
          end
        end
        S_LD_MUL: begin
          p0 <= XP_W'(ax) * XP_W'(by);
          p1 <= XP_W'(bx) * XP_W'(ay);
          state <= S_LD_FIN;
        end
        S_LD_FIN: begin
          rz    <= p0 - p1;
          degen <= ((p0 - p1) > -rzb_pkg::AREA_MIN) && ((p0 - p1) < rzb_pkg::AREA_MIN);
          state <= S_DONE;
        end
        S_XP_MUL: begin
          p0 <= XP_W'(bx) * XP_W'(cy);
          p1 <= XP_W'(cx) * XP_W'(by);
          p2 <= XP_W'(cx) * XP_W'(ay);
          p3 <= XP_W'(ax) * XP_W'(cy);
          row_prod <= RP_W'(sy) * RP_W'(signed'({1'b0, wsat}));
          state <= S_XP_CHK;
        end
        S_XP_CHK: begin
          pix_addr <= addr_full[ADDR_W-1:0];
          state    <= (covered && in_bounds) ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (!div_busy1 && !div_busy2) state <= S_ZMUL;
        end
        S_ZMUL: begin
          m0 <= ACC_W'(w0) * ACC_W'(vz[0]);
          m1 <= ACC_W'(w1) * ACC_W'(vz[1]);
          m2 <= ACC_W'(w2) * ACC_W'(vz[2]);
          state <= S_ZSUM;
        end
        S_ZSUM: begin
          if (depth_pass) begin
            res_written <= 1'b1;
            res_px      <= rzb_pkg::PIX_W'(sx) - off_x;
            res_py      <= rzb_pkg::PIX_W'(sy) - off_y;
            res_depth   <= dz;
            res_shade   <= shade_h;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            written   <= res_written;
            pixel_x   <= res_px;
            pixel_y   <= res_py;
            depth     <= res_depth;
            shade     <= res_shade;
            last      <= (sy_next == by1);
            sx        <= sx_next;
            sy        <= sy_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall) else $error("input taken during clearing pass");

  a_written_beats_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && written) |-> (depth != rzb_pkg::DEPTH_MIN))
    else $error("written pixel carries most negative depth");

  a_store_write_source: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !clearing) |-> (state == S_ZSUM))
    else $error("depth store written outside depth test");

endmodule
